// ===== rtl/rie_pkg.sv =====
// shared types and constants for the register instruction execute unit
package rie_pkg;

    localparam int NumRegs   = 32;

    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd3;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_MFHI = 6'd16;
    localparam logic [5:0] FN_MFLO = 6'd18;
    localparam logic [5:0] FN_MUL  = 6'd25;
    localparam logic [5:0] FN_DIV  = 6'd27;
    localparam logic [5:0] FN_ADD  = 6'd33;
    localparam logic [5:0] FN_SUB  = 6'd35;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_XOR  = 6'd38;
    localparam logic [5:0] FN_NOR  = 6'd39;

    localparam logic [31:0] JR_OFFSET = 32'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_OP = 2'd1;
    localparam logic [1:0] ST_BAD_FN = 2'd2;

    typedef struct packed {
        logic [5:0] op_code;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dest;
        logic [4:0] shift_amount;
        logic [5:0] func_code;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        reg_written;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        jump_taken;
        logic [31:0] jump_target;
    } t_rsp;

    // control from sequencer to the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_md_sts;

endpackage

// ===== rtl/rie_muldiv.sv =====
// iterative shared add/subtract unit for signed multiply and divide
module rie_muldiv
    import rie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_md_ctl     i_ctl,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_md_sts     o_sts,
    output logic [31:0] o_hi,
    output logic [31:0] o_lo
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_div,  n_div;
    logic [5:0]  r_cnt,  n_cnt;
    logic [31:0] r_acc,  n_acc;   // high half / remainder
    logic [31:0] r_q,    n_q;     // low half / quotient
    logic [31:0] r_m,    n_m;     // multiplicand or |divisor|
    logic        r_neg_q, n_neg_q;
    logic        r_neg_r, n_neg_r;

    logic [32:0] w_sum;
    logic [32:0] w_trial;
    logic [31:0] w_abs_a, w_abs_b;

    assign w_abs_a = i_a[31] ? (32'd0 - i_a) : i_a;
    assign w_abs_b = i_b[31] ? (32'd0 - i_b) : i_b;
    // booth-free signed multiply: last step subtracts (sign weight)
    assign w_sum   = (r_cnt == 6'd31)
                   ? {r_acc[31], r_acc} - {r_m[31], r_m}
                   : {r_acc[31], r_acc} + {r_m[31], r_m};
    assign w_trial = {r_acc, r_q[31]} - {1'b0, r_m};

    always_comb begin
        n_busy = r_busy; n_done = 1'b0; n_div = r_div; n_cnt = r_cnt;
        n_acc = r_acc; n_q = r_q; n_m = r_m; n_neg_q = r_neg_q; n_neg_r = r_neg_r;
        if (i_ctl.start) begin
            n_busy = 1'b1; n_div = i_ctl.is_div; n_cnt = 6'd0; n_acc = 32'd0;
            if (i_ctl.is_div) begin
                n_q = w_abs_a; n_m = w_abs_b;
                n_neg_q = i_a[31] ^ i_b[31]; n_neg_r = i_a[31];
            end else begin
                n_q = i_b; n_m = i_a;
            end
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_trial[32]) begin
                    n_acc = w_trial[31:0]; n_q = {r_q[30:0], 1'b1};
                end else begin
                    n_acc = {r_acc[30:0], r_q[31]}; n_q = {r_q[30:0], 1'b0};
                end
            end else begin
                if (r_q[0]) {n_acc, n_q} = {w_sum, r_q[31:1]};
                else        {n_acc, n_q} = {r_acc[31], r_acc, r_q[31:1]};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_div <= n_div; r_cnt <= n_cnt; r_acc <= n_acc; r_q <= n_q; r_m <= n_m;
        r_neg_q <= n_neg_q; r_neg_r <= n_neg_r;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_hi = (r_div && r_neg_r) ? (32'd0 - r_acc) : r_acc;
    assign o_lo = (r_div && r_neg_q) ? (32'd0 - r_q) : r_q;

endmodule

// ===== rtl/register_instruction_execute_unit.sv =====
// top level: register-format instruction execute unit
// Executes one decoded register instruction per request against a 32 x 32 register
// file and HI/LO. A simple ALU request (and a DIV by zero) reads its operands and
// registers its result straight into the output register; MUL and DIV run on a shared
// one-bit-per-cycle add/subtract unit over its 32 iterations, after operand read and
// unit load and before result hand-off. One request is in flight at a time; the result
// sits in an output register and a new request is taken once it is gone.
// The register file resets to zero through a valid bit per entry.
module register_instruction_execute_unit
    import rie_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_MD, S_OUT} t_state;

    t_state             r_state;
    t_req               r_req;
    logic [31:0]        r_rf [NumRegs];
    logic [NumRegs-1:0] r_rf_vld;
    logic [31:0]        r_a, r_b;
    logic [31:0]        r_hi, r_lo;
    logic               r_out_vld;
    t_rsp               r_rsp;
    t_md_ctl            w_md_ctl;
    t_md_sts            w_md_sts;
    logic [31:0]        w_md_hi, w_md_lo;
    t_rsp               w_rsp;

    // shared iterative multiply/divide
    rie_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_md_ctl),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_sts  (w_md_sts),
        .o_hi   (w_md_hi),
        .o_lo   (w_md_lo)
    );

    // stall while busy or while the result waits
    assign o_stall = (r_state != S_IDLE);

    logic w_is_md;
    assign w_is_md = (r_req.op_code == 6'd0) &&
                     ((r_req.func_code == FN_MUL) ||
                      ((r_req.func_code == FN_DIV) && (r_b != 32'd0)));
    assign w_md_ctl.start  = (r_state == S_READ) && w_is_md;
    assign w_md_ctl.is_div = (r_req.func_code == FN_DIV);

    // simple ALU result from latched operands
    always_comb begin
        w_rsp = '0;
        w_rsp.hi_value = r_hi;
        w_rsp.lo_value = r_lo;
        if (r_req.op_code != 6'd0) begin
            w_rsp.status = ST_BAD_OP;
        end else begin
            w_rsp.status = ST_OK;
            w_rsp.reg_written = 1'b1;
            case (r_req.func_code)
                FN_ADD:  w_rsp.write_value = r_a + r_b;
                FN_SUB:  w_rsp.write_value = r_a - r_b;
                FN_MFHI: w_rsp.write_value = r_hi;
                FN_MFLO: w_rsp.write_value = r_lo;
                FN_AND:  w_rsp.write_value = r_a & r_b;
                FN_OR:   w_rsp.write_value = r_a | r_b;
                FN_NOR:  w_rsp.write_value = ~(r_a | r_b);
                FN_XOR:  w_rsp.write_value = r_a ^ r_b;
                FN_SLL:  w_rsp.write_value = r_b << r_req.shift_amount;
                FN_SRL:  w_rsp.write_value = r_b >> r_req.shift_amount;
                FN_MUL, FN_DIV: w_rsp.reg_written = 1'b0;
                FN_JR: begin
                    w_rsp.reg_written = 1'b0;
                    w_rsp.jump_taken  = 1'b1;
                    w_rsp.jump_target = r_a - JR_OFFSET;
                end
                default: begin
                    w_rsp.reg_written = 1'b0;
                    w_rsp.status      = ST_BAD_FN;
                end
            endcase
            if (w_rsp.reg_written) w_rsp.write_index = r_req.dest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rf_vld  <= '0;
            r_hi      <= 32'd0;
            r_lo      <= 32'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_req;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (w_is_md) begin
                        r_state <= S_MD;
                    end else begin
                        r_rsp     <= w_rsp;
                        r_out_vld <= 1'b1;
                        r_state   <= S_OUT;
                        if (w_rsp.reg_written) begin
                            r_rf[r_req.dest]     <= w_rsp.write_value;
                            r_rf_vld[r_req.dest] <= 1'b1;
                        end
                    end
                end
                S_MD: begin
                    if (w_md_sts.done) begin
                        r_hi      <= w_md_hi;
                        r_lo      <= w_md_lo;
                        // only HI and LO are reported for multiply and divide
                        r_rsp     <= {ST_OK, 1'b0, 5'd0, 32'd0, w_md_hi, w_md_lo,
                                      1'b0, 32'd0};
                        r_out_vld <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_out_vld <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // operand read, registered together with the accepted request
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_a <= r_rf_vld[i_req.src_a] ? r_rf[i_req.src_a] : 32'd0;
            r_b <= r_rf_vld[i_req.src_b] ? r_rf[i_req.src_b] : 32'd0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

    // result only while the output stage is occupied
    a_vld_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT)) else $error("result valid outside output state");
    // unit finishes only while waiting on it
    a_md_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_sts.done |-> (r_state == S_MD)) else $error("muldiv done unexpected");
    // never take a request while one is in flight
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_md_sts.busy || o_valid) |-> o_stall) else $error("accept while busy");
    // a jump never writes a register
    a_jr_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.jump_taken) |-> !o_rsp.reg_written) else $error("jump wrote reg");

endmodule
